// ----- design/rcpp_pkg.sv -----
`default_nettype none

package rcpp_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_COLOR_MODE  = 3'd0;
    localparam logic [2:0] REG_PAGE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_PAGE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_LEFT_OFFSET = 3'd3;
    localparam logic [2:0] REG_TOP_OFFSET  = 3'd4;
    localparam logic [2:0] REG_MARGIN_DOTS = 3'd5;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;

    localparam logic        RST_COLOR_MODE  = 1'b1;
    localparam logic [12:0] RST_PAGE_WIDTH  = 13'd5100;
    localparam logic [12:0] RST_PAGE_HEIGHT = 13'd6600;
    localparam logic [12:0] RST_LEFT_OFFSET = 13'd0;
    localparam logic [12:0] RST_TOP_OFFSET  = 13'd0;
    localparam logic [7:0]  RST_MARGIN_DOTS = 8'd97;

    localparam logic [7:0] INK_FULL = 8'd255;

    typedef struct packed {
        logic [12:0] column;
        logic [12:0] row_index;
        logic [7:0]  red_or_gray;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_in_word;

    typedef struct packed {
        logic        write_enable;
        logic [27:0] address;
        logic [7:0]  black;
        logic [7:0]  cyan;
        logic [7:0]  magenta;
        logic [7:0]  yellow;
    } t_out_word;

    typedef struct packed {
        logic        color_mode;
        logic [12:0] page_width;
        logic [12:0] page_height;
        logic [12:0] left_offset;
        logic [12:0] top_offset;
        logic [7:0]  margin_dots;
    } t_cfg;

    // One lane of the restoring divider: partial remainder, dividend bits
    // not yet shifted in (msb first), quotient bits so far.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
    } t_div_lane;

    // Per-stage load enables of the three inner pipeline stages.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    // Two restoring division steps. Remainder stays below the divisor.
    // A zero divisor always subtracts, so a zero dividend gives all ones.
    function automatic t_div_lane div2(input t_div_lane cur, input logic [7:0] den);
        t_div_lane  nxt;
        logic [8:0] t;
        nxt = cur;
        for (int i = 0; i < 2; i++) begin
            t       = {nxt.rem, nxt.low[7]};
            nxt.low = {nxt.low[6:0], 1'b0};
            if (t >= {1'b0, den}) begin
                nxt.rem = 8'(t - {1'b0, den});
                nxt.quo = {nxt.quo[6:0], 1'b1};
            end else begin
                nxt.rem = t[7:0];
                nxt.quo = {nxt.quo[6:0], 1'b0};
            end
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- design/rcpp_cfg_regs.sv -----
`default_nettype none

module rcpp_cfg_regs
    import rcpp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode  <= RST_COLOR_MODE;
            r_cfg.page_width  <= RST_PAGE_WIDTH;
            r_cfg.page_height <= RST_PAGE_HEIGHT;
            r_cfg.left_offset <= RST_LEFT_OFFSET;
            r_cfg.top_offset  <= RST_TOP_OFFSET;
            r_cfg.margin_dots <= RST_MARGIN_DOTS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COLOR_MODE:  r_cfg.color_mode  <= i_cfg_data[0];
                REG_PAGE_WIDTH:  r_cfg.page_width  <= i_cfg_data[12:0];
                REG_PAGE_HEIGHT: r_cfg.page_height <= i_cfg_data[12:0];
                REG_LEFT_OFFSET: r_cfg.left_offset <= i_cfg_data[12:0];
                REG_TOP_OFFSET:  r_cfg.top_offset  <= i_cfg_data[12:0];
                REG_MARGIN_DOTS: r_cfg.margin_dots <= i_cfg_data[7:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- design/rcpp_ink_div.sv -----
`default_nettype none

module rcpp_ink_div
    import rcpp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_stage_en   i_en,
    input  wire logic [15:0] i_num [3],
    input  wire logic [7:0]  i_den,
    output logic      [7:0]  o_quo [3]
);

    // Quotient < 256 because dividend < 256 * divisor. Two bits per stage.
    t_div_lane  r_s2 [3];
    t_div_lane  r_s3 [3];
    t_div_lane  r_s4 [3];
    logic [7:0] r_den_s2;
    logic [7:0] r_den_s3;
    logic [7:0] r_den_s4;
    t_div_lane  n_s2 [3];
    t_div_lane  w_last [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s2[c]   = div2('{rem: i_num[c][15:8], low: i_num[c][7:0], quo: 8'd0}, i_den);
            w_last[c] = div2(r_s4[c], r_den_s4);
            o_quo[c]  = w_last[c].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2     <= n_s2;
            r_den_s2 <= i_den;
        end
        if (i_en.s3) begin
            for (int c = 0; c < 3; c++) r_s3[c] <= div2(r_s2[c], r_den_s2);
            r_den_s3 <= r_den_s2;
        end
        if (i_en.s4) begin
            for (int c = 0; c < 3; c++) r_s4[c] <= div2(r_s3[c], r_den_s3);
            r_den_s4 <= r_den_s3;
        end
    end

endmodule

`default_nettype wire

// ----- design/rcpp_addr_pipe.sv -----
`default_nettype none

module rcpp_addr_pipe
    import rcpp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_stage_en   i_en,
    input  wire logic [13:0] i_dx,
    input  wire logic [13:0] i_dy,
    input  wire logic [13:0] i_stride,
    input  wire logic        i_color,
    output logic      [27:0] o_addr
);

    logic [27:0] r_prod;
    logic [13:0] r_dx_s2;
    logic        r_color_s2;
    logic [27:0] r_addr_s3;
    logic [27:0] r_addr_s4;
    logic [27:0] n_sum;

    // pixel index in the padded buffer, then times plane depth, mod 2^28
    assign n_sum = r_prod + 28'(r_dx_s2) + 28'd1;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod     <= 28'(i_dy + 14'd1) * 28'(i_stride);
            r_dx_s2    <= i_dx;
            r_color_s2 <= i_color;
        end
        if (i_en.s3) begin
            r_addr_s3 <= r_color_s2 ? {n_sum[25:0], 2'b00} : n_sum;
        end
        if (i_en.s4) begin
            r_addr_s4 <= r_addr_s3;
        end
    end

    assign o_addr = r_addr_s4;

endmodule

`default_nettype wire

// ----- design/rgb_to_cmyk_page_placer_unit.sv -----
`default_nettype none

// RGB to CMYK page placer.
// Input channel: i_in_valid / o_in_stall carry one pixel word (column, row,
// R/gray, G, B). Output channel: o_out_valid / i_out_stall carry one result
// word (write_enable, byte address, K, C, M, Y). A word moves at a clock
// edge with valid high and stall low.
// Every input word gives exactly one output word, in order.
// Five register stages: front end (placement, margin test, max, dividends),
// three stages of a 2-bit-per-stage restoring divider for C/M/Y together
// with the address multiply and add, and the output register.
// Throughput: one word per clock, limited only by the output stall.
// When the receiver stalls, the pipeline keeps filling bubbles; o_in_stall
// rises only when all five stages hold words. Nothing is dropped or repeated.
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, one register per write;
// write only while no word is in flight.
// Reset (synchronous, active low) empties the pipeline and loads register
// defaults: color mode, 5100 x 6600 page, zero offsets, 97-dot margin.
module rgb_to_cmyk_page_placer_unit
    import rcpp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire t_in_word               i_in_word,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output t_out_word                   o_out_word,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef struct packed {
        logic       printable;
        logic       color;
        logic [7:0] black;
    } t_meta;

    t_cfg        w_cfg;

    // stage valids and ready chain; stage 5 is the output register
    logic [5:1]  r_vld;
    logic [5:1]  w_rdy;
    t_stage_en   w_en;

    // front end
    logic [13:0] n_dx;
    logic [13:0] n_dy;
    logic        n_inside;
    logic [13:0] n_stride;
    logic [7:0]  n_k;
    logic [15:0] n_num [3];
    logic [7:0]  w_diff [3];
    logic [7:0]  w_ch [3];

    logic [13:0] r1_dx;
    logic [13:0] r1_dy;
    logic [13:0] r1_stride;
    logic [7:0]  r1_k;
    logic [15:0] r1_num [3];
    t_meta       r1_meta;
    t_meta       r2_meta;
    t_meta       r3_meta;
    t_meta       r4_meta;
    t_meta       n1_meta;

    logic [7:0]  w_quo [3];
    logic [27:0] w_addr;
    t_out_word   r_out;
    t_out_word   n_out;

    rcpp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // ready of a stage: empty, or its word moves on this edge
    assign w_rdy[5] = !r_vld[5] || !i_out_stall;
    assign w_rdy[4] = !r_vld[4] || w_rdy[5];
    assign w_rdy[3] = !r_vld[3] || w_rdy[4];
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_en     = '{s2: w_rdy[2], s3: w_rdy[3], s4: w_rdy[4]};
    assign o_in_stall = !w_rdy[1];

    // placement and margin test; dx + m < w is dx < w - m without signs
    always_comb begin
        n_dx     = 14'(i_in_word.column) + 14'(w_cfg.left_offset);
        n_dy     = 14'(i_in_word.row_index) + 14'(w_cfg.top_offset);
        n_inside = (n_dx >= 14'(w_cfg.margin_dots))
                && ((15'(n_dx) + 15'(w_cfg.margin_dots)) < 15'(w_cfg.page_width))
                && (n_dy >= 14'(w_cfg.margin_dots))
                && ((15'(n_dy) + 15'(w_cfg.margin_dots)) < 15'(w_cfg.page_height));
        n_stride = (14'(w_cfg.page_width) + 14'd7) & ~14'd7;
    end

    // k = max channel; dividend (k - ch) * 255 as (d << 8) - d
    always_comb begin
        w_ch[0] = i_in_word.red_or_gray;
        w_ch[1] = i_in_word.green;
        w_ch[2] = i_in_word.blue;
        n_k = i_in_word.red_or_gray;
        if (n_k < i_in_word.green) n_k = i_in_word.green;
        if (n_k < i_in_word.blue)  n_k = i_in_word.blue;
        for (int c = 0; c < 3; c++) begin
            w_diff[c] = n_k - w_ch[c];
            n_num[c]  = {w_diff[c], 8'd0} - {8'd0, w_diff[c]};
        end
        n1_meta.printable = n_inside;
        n1_meta.color     = w_cfg.color_mode;
        n1_meta.black     = w_cfg.color_mode ? (INK_FULL - n_k)
                                             : (INK_FULL - i_in_word.red_or_gray);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) r_vld[1] <= i_in_valid;
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
            if (w_rdy[3]) r_vld[3] <= r_vld[2];
            if (w_rdy[4]) r_vld[4] <= r_vld[3];
            if (w_rdy[5]) r_vld[5] <= r_vld[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_dx     <= n_dx;
            r1_dy     <= n_dy;
            r1_stride <= n_stride;
            r1_k      <= n_k;
            r1_num    <= n_num;
            r1_meta   <= n1_meta;
        end
        if (w_rdy[2]) r2_meta <= r1_meta;
        if (w_rdy[3]) r3_meta <= r2_meta;
        if (w_rdy[4]) r4_meta <= r3_meta;
        if (w_rdy[5]) r_out   <= n_out;
    end

    rcpp_ink_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r1_num),
        .i_den (r1_k),
        .o_quo (w_quo)
    );

    rcpp_addr_pipe u_addr (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_dx     (r1_dx),
        .i_dy     (r1_dy),
        .i_stride (r1_stride),
        .i_color  (r1_meta.color),
        .o_addr   (w_addr)
    );

    // dropped pixel: all fields zero; gray mode: no color planes
    always_comb begin
        n_out = '0;
        if (r4_meta.printable) begin
            n_out.write_enable = 1'b1;
            n_out.address      = w_addr;
            n_out.black        = r4_meta.black;
            if (r4_meta.color) begin
                n_out.cyan    = w_quo[0];
                n_out.magenta = w_quo[1];
                n_out.yellow  = w_quo[2];
            end
        end
    end

    assign o_out_valid = r_vld[5];
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && (&r_vld)))
        else $error("input stalled while pipeline has room");

    a_dropped_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.write_enable) |->
        (o_out_word.address == 28'd0 && o_out_word.black == 8'd0
         && o_out_word.cyan == 8'd0 && o_out_word.magenta == 8'd0
         && o_out_word.yellow == 8'd0))
        else $error("dropped pixel carries nonzero fields");

    a_stage4_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !w_rdy[5]) |=> r_vld[4])
        else $error("stage 4 word lost under stall");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// ----- dv/rgb_to_cmyk_page_placer_unit_tb.sv -----
`timescale 1ns / 100ps

module rgb_to_cmyk_page_placer_unit_tb;
    import rcpp_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RST_CYCLES      = 9;
    localparam int PIPE_DEPTH      = 5;        // five register stages
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 63;
    localparam int MAX_REPORTS     = 200;

    // Indexes past the last register; the block must ignore writes there.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_in_word               i_in_word   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_word              o_out_word;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Pixel words waiting for the driver, and predicted result words in order.
    t_in_word    pending_pixels[$];
    t_out_word   expected_results[$];

    // Our own copy of the page setup registers.
    t_cfg        page_cfg;

    int          mismatches  = 0;
    int          reports     = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          stall_hold  = 0;
    t_stall_mode stall_mode  = STALL_NONE;

    rgb_to_cmyk_page_placer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: page placement, margin test, address and ink amounts
    // ------------------------------------------------------------------

    // Share of one ink: (k - ch) * 255 / k, truncated; full ink when k is zero.
    function automatic logic [7:0] ink_share(input int k, input int ch);
        if (k == 0)
            return INK_FULL;
        return 8'(((k - ch) * 255) / k);
    endfunction

    function automatic t_out_word place_and_convert(input t_in_word px);
        t_out_word res;
        int        dx, dy, m, w, h, stride, depth, k;
        longint    addr;
        res = '0;
        m   = int'(page_cfg.margin_dots);
        w   = int'(page_cfg.page_width);
        h   = int'(page_cfg.page_height);
        dx  = int'(page_cfg.left_offset) + int'(px.column);
        dy  = int'(page_cfg.top_offset) + int'(px.row_index);
        // Signed compare: a margin too big for the page drops everything.
        if (dx < m || dx >= w - m || dy < m || dy >= h - m)
            return res;
        stride = (w + 7) & ~7;
        depth  = page_cfg.color_mode ? 4 : 1;
        addr   = ((longint'(dy) + 1) * stride + dx + 1) * depth;
        res.write_enable = 1'b1;
        res.address      = 28'(addr);
        if (!page_cfg.color_mode) begin
            res.black = 8'(255 - int'(px.red_or_gray));
            return res;
        end
        k = int'(px.red_or_gray);
        if (k < int'(px.green)) k = int'(px.green);
        if (k < int'(px.blue))  k = int'(px.blue);
        res.black   = 8'(255 - k);
        res.cyan    = ink_share(k, int'(px.red_or_gray));
        res.magenta = ink_share(k, int'(px.green));
        res.yellow  = ink_share(k, int'(px.blue));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Raster coordinate that lands at page position d, with d inside [lo, hi]
    // or right on / just past one of its ends. Falls back to a random
    // coordinate when the target can't be reached from this offset.
    function automatic logic [12:0] place_coord(input int off, input int lo, input int hi,
                                                input bit at_border);
        int d;
        if (hi < lo)
            return 13'($urandom);
        if (at_border) begin
            case ($urandom_range(0, 3))
                0:       d = lo - 1;
                1:       d = lo;
                2:       d = hi;
                default: d = hi + 1;
            endcase
        end else
            d = $urandom_range(lo, hi);
        if (d < off || d - off > 8191)
            return 13'($urandom);
        return 13'(d - off);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_COLOR_MODE:  page_cfg.color_mode  = data[0];
            REG_PAGE_WIDTH:  page_cfg.page_width  = data;
            REG_PAGE_HEIGHT: page_cfg.page_height = data;
            REG_LEFT_OFFSET: page_cfg.left_offset = data;
            REG_TOP_OFFSET:  page_cfg.top_offset  = data;
            REG_MARGIN_DOTS: page_cfg.margin_dots = data[7:0];
            default: ;
        endcase
    endtask

    // Full register load. Narrow registers get junk in the unused data bits,
    // and one write goes to an index past the register file.
    task automatic load_page_setup(input t_cfg c);
        write_reg(REG_COLOR_MODE,  {12'($urandom), c.color_mode});
        write_reg(REG_PAGE_WIDTH,  c.page_width);
        write_reg(REG_PAGE_HEIGHT, c.page_height);
        write_reg(REG_LEFT_OFFSET, c.left_offset);
        write_reg(REG_TOP_OFFSET,  c.top_offset);
        write_reg(REG_MARGIN_DOTS, {5'($urandom), c.margin_dots});
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 13'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender holds off until every predicted word has come back.
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [27:0] want,
                               input logic [27:0] got);
        if (want !== got) begin
            mismatches++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps; a word is held while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                // word on the port moved at this edge: predict its result now
                if (i_in_valid)
                    expected_results.push_back(place_and_convert(i_in_word));
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    i_in_word  <= pending_pixels.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        // a third of the bursts run straight into the next
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else
                        burst_left <= burst_left - 1;
                end else
                    i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result word, and drives the stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t ns: result word with none expected, expected none, actual %h",
                             $time, o_out_word);
                end
            end else begin
                want = expected_results.pop_front();
                check_field("write_enable", want.write_enable, o_out_word.write_enable);
                check_field("address",      want.address,      o_out_word.address);
                check_field("black",        want.black,        o_out_word.black);
                check_field("cyan",         want.cyan,         o_out_word.cyan);
                check_field("magenta",      want.magenta,      o_out_word.magenta);
                check_field("yellow",       want.yellow,       o_out_word.yellow);
            end
        end
        // stall pattern: picks a new random style each time the hold count runs out
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(20, 150);
        end else
            stall_hold <= stall_hold - 1;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 9) < 2);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
            default:     i_out_stall <= ~i_out_stall;
        endcase
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg     setup;
        t_in_word px;
        int       lo_x, hi_x, lo_y, hi_y, kind;
        bit       border_x, border_y;

        page_cfg = '{RST_COLOR_MODE, RST_PAGE_WIDTH, RST_PAGE_HEIGHT,
                     RST_LEFT_OFFSET, RST_TOP_OFFSET, RST_MARGIN_DOTS};
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setup: color, 5100 x 6600, margin 97. Edges of the printable
        // area on all four sides, plus ink corner cases.
        pending_pixels.push_back(t_in_word'{13'd96,   13'd500,  8'd10,  8'd20,  8'd30});
        pending_pixels.push_back(t_in_word'{13'd97,   13'd97,   8'd100, 8'd50,  8'd25});
        pending_pixels.push_back(t_in_word'{13'd5002, 13'd6502, 8'd255, 8'd255, 8'd255});
        pending_pixels.push_back(t_in_word'{13'd5003, 13'd1000, 8'd1,   8'd2,   8'd3});
        pending_pixels.push_back(t_in_word'{13'd1000, 13'd6503, 8'd1,   8'd2,   8'd3});
        pending_pixels.push_back(t_in_word'{13'd1000, 13'd96,   8'd1,   8'd2,   8'd3});
        pending_pixels.push_back(t_in_word'{13'd200,  13'd300,  8'd0,   8'd0,   8'd0});
        pending_pixels.push_back(t_in_word'{13'd201,  13'd300,  8'd255, 8'd0,   8'd0});
        pending_pixels.push_back(t_in_word'{13'd202,  13'd300,  8'd0,   8'd255, 8'd0});
        pending_pixels.push_back(t_in_word'{13'd203,  13'd300,  8'd0,   8'd0,   8'd255});
        pending_pixels.push_back(t_in_word'{13'h1FFF, 13'h1FFF, 8'd255, 8'd255, 8'd255});
        pending_pixels.push_back(t_in_word'{13'd0,    13'd0,    8'd9,   8'd9,   8'd9});
        pending_pixels.push_back(t_in_word'{13'd204,  13'd301,  8'd7,   8'd200, 8'd13});
        wait_idle();

        // Gray mode: green and blue must be ignored, no C/M/Y.
        setup = '{1'b0, RST_PAGE_WIDTH, RST_PAGE_HEIGHT, 13'd0, 13'd0, 8'd97};
        load_page_setup(setup);
        pending_pixels.push_back(t_in_word'{13'd300, 13'd400, 8'd0,   8'd255, 8'd255});
        pending_pixels.push_back(t_in_word'{13'd301, 13'd400, 8'd255, 8'd17,  8'd0});
        pending_pixels.push_back(t_in_word'{13'd302, 13'd400, 8'd128, 8'd0,   8'd99});
        wait_idle();

        // Largest page, no margin: top of the address range.
        setup = '{1'b1, 13'h1FFF, 13'h1FFF, 13'd0, 13'd0, 8'd0};
        load_page_setup(setup);
        pending_pixels.push_back(t_in_word'{13'd8190, 13'd8190, 8'd40,  8'd80,  8'd120});
        pending_pixels.push_back(t_in_word'{13'd0,    13'd0,    8'd1,   8'd0,   8'd0});
        pending_pixels.push_back(t_in_word'{13'h1FFF, 13'd0,    8'd1,   8'd0,   8'd0});
        wait_idle();

        // Margin wider than the page, maximum offsets: every pixel dropped.
        setup = '{1'b1, 13'd100, 13'd100, 13'h1FFF, 13'h1FFF, 8'd255};
        load_page_setup(setup);
        pending_pixels.push_back(t_in_word'{13'd50, 13'd50, 8'd60, 8'd70, 8'd80});
        pending_pixels.push_back(t_in_word'{13'd0,  13'd0,  8'd60, 8'd70, 8'd80});
        wait_idle();

        // Random phases: new page setup, then a batch of pixels aimed mostly
        // at the printable area, some at its borders, some anywhere.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            setup.color_mode = 1'($urandom);
            case ($urandom_range(0, 5))
                0:       setup.page_width = 13'd4958;
                1:       setup.page_width = RST_PAGE_WIDTH;
                2:       setup.page_width = 13'h1FFF;
                3:       setup.page_width = 13'($urandom);
                default: setup.page_width = 13'($urandom_range(4958, 5100));
            endcase
            case ($urandom_range(0, 5))
                0:       setup.page_height = RST_PAGE_HEIGHT;
                1:       setup.page_height = 13'd7017;
                2:       setup.page_height = 13'h1FFF;
                3:       setup.page_height = 13'($urandom);
                default: setup.page_height = 13'($urandom_range(6600, 7017));
            endcase
            case ($urandom_range(0, 4))
                0:       setup.left_offset = 13'd0;
                1:       setup.left_offset = 13'($urandom);
                default: setup.left_offset = 13'($urandom_range(0, 300));
            endcase
            case ($urandom_range(0, 4))
                0:       setup.top_offset = 13'd0;
                1:       setup.top_offset = 13'($urandom);
                default: setup.top_offset = 13'($urandom_range(0, 300));
            endcase
            case ($urandom_range(0, 4))
                0:       setup.margin_dots = 8'd0;
                1:       setup.margin_dots = 8'd255;
                default: setup.margin_dots = 8'($urandom);
            endcase
            load_page_setup(setup);

            lo_x = int'(page_cfg.margin_dots);
            hi_x = int'(page_cfg.page_width) - lo_x - 1;
            lo_y = lo_x;
            hi_y = int'(page_cfg.page_height) - lo_y - 1;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                kind     = $urandom_range(0, 19);
                border_x = (kind >= 12 && kind < 17) && $urandom_range(0, 1);
                border_y = (kind >= 12 && kind < 17) && (!border_x || $urandom_range(0, 1));
                if (kind >= 17) begin
                    px.column    = 13'($urandom);
                    px.row_index = 13'($urandom);
                end else begin
                    px.column    = place_coord(int'(page_cfg.left_offset), lo_x, hi_x,
                                               border_x);
                    px.row_index = place_coord(int'(page_cfg.top_offset), lo_y, hi_y,
                                               border_y);
                end
                px.red_or_gray = 8'($urandom);
                px.green       = 8'($urandom);
                px.blue        = 8'($urandom);
                case ($urandom_range(0, 7))
                    0: begin                        // zero maximum
                        px.red_or_gray = '0;
                        px.green       = '0;
                        px.blue        = '0;
                    end
                    1: begin                        // neutral color, equal channels
                        px.green = px.red_or_gray;
                        px.blue  = px.red_or_gray;
                    end
                    2: begin                        // tiny divisor
                        px.red_or_gray = 8'($urandom_range(0, 3));
                        px.green       = 8'($urandom_range(0, 3));
                        px.blue        = 8'($urandom_range(0, 3));
                    end
                    default: ;
                endcase
                pending_pixels.push_back(px);
            end
            wait_idle();
        end

        // drain, then let any stray word surface
        wait_idle();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- rgb_to_cmyk_page_placer_unit.f -----
design/rcpp_pkg.sv
design/rcpp_cfg_regs.sv
design/rcpp_ink_div.sv
design/rcpp_addr_pipe.sv
design/rgb_to_cmyk_page_placer_unit.sv
dv/rgb_to_cmyk_page_placer_unit_tb.sv
